// ----- hw/rtl/idv_pkg.sv -----
`timescale 1ns / 1ps

package idv_pkg;

   // Width of every data port on the block
   localparam int FIELD_WIDTH = 64;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;    // capture a new word
      logic prep;    // take magnitudes, record result signs
      logic step;    // one shift-subtract iteration
      logic fix;     // apply result signs
   } idv_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic div_zero;
   } idv_status_type;

endpackage

// ----- hw/rtl/idv_datapath.sv -----
`timescale 1ns / 1ps

module idv_datapath #(
   parameter int DATA_WIDTH = 64
) (
   input  logic                          clock,
   input  idv_pkg::idv_cmd_type          cmd,
   output idv_pkg::idv_status_type       status,
   input  logic                          opcode,
   input  logic [idv_pkg::FIELD_WIDTH-1:0] dividend,
   input  logic [idv_pkg::FIELD_WIDTH-1:0] divisor,
   output logic [idv_pkg::FIELD_WIDTH-1:0] quotient,
   output logic [idv_pkg::FIELD_WIDTH-1:0] remainder,
   output logic                          div_by_zero
);
   import idv_pkg::*;

   localparam int PAD = FIELD_WIDTH - DATA_WIDTH;

   // q_ff holds the dividend bits not yet shifted out, then the quotient
   logic [DATA_WIDTH-1:0] q_ff, q_in;
   logic [DATA_WIDTH-1:0] r_ff, r_in;
   logic [DATA_WIDTH-1:0] d_ff, d_in;
   logic                  sgn_ff, sgn_in;
   logic                  zero_ff, zero_in;
   logic                  neg_q_ff, neg_q_in;
   logic                  neg_r_ff, neg_r_in;

   logic [DATA_WIDTH:0]   rem_shift;
   logic [DATA_WIDTH:0]   diff;
   logic                  a_neg, b_neg;

   assign rem_shift = {r_ff, q_ff[DATA_WIDTH-1]};
   assign diff      = rem_shift - {1'b0, d_ff};
   assign a_neg     = sgn_ff & q_ff[DATA_WIDTH-1];
   assign b_neg     = sgn_ff & d_ff[DATA_WIDTH-1];

   always_comb begin
      q_in     = q_ff;
      r_in     = r_ff;
      d_in     = d_ff;
      sgn_in   = sgn_ff;
      zero_in  = zero_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      if (cmd.load) begin
         q_in    = dividend[DATA_WIDTH-1:0];
         d_in    = divisor[DATA_WIDTH-1:0];
         r_in    = '0;
         sgn_in  = opcode;
         zero_in = (divisor[DATA_WIDTH-1:0] == '0);
      end else if (cmd.prep) begin
         if (a_neg) q_in = '0 - q_ff;
         if (b_neg) d_in = '0 - d_ff;
         neg_q_in = a_neg ^ b_neg;
         neg_r_in = a_neg;
      end else if (cmd.step) begin
         // no borrow: the divisor fits, keep the difference
         if (!diff[DATA_WIDTH]) begin
            r_in = diff[DATA_WIDTH-1:0];
            q_in = {q_ff[DATA_WIDTH-2:0], 1'b1};
         end else begin
            r_in = rem_shift[DATA_WIDTH-1:0];
            q_in = {q_ff[DATA_WIDTH-2:0], 1'b0};
         end
      end else if (cmd.fix) begin
         if (neg_q_ff) q_in = '0 - q_ff;
         if (neg_r_ff) r_in = '0 - r_ff;
      end
   end

   always_ff @(posedge clock) begin
      q_ff     <= q_in;
      r_ff     <= r_in;
      d_ff     <= d_in;
      sgn_ff   <= sgn_in;
      zero_ff  <= zero_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
   end

   assign status.div_zero = zero_ff;

   generate
      if (PAD > 0) begin : g_pad
         assign quotient  = zero_ff ? '0 : {{PAD{1'b0}}, q_ff};
         assign remainder = zero_ff ? '0 : {{PAD{1'b0}}, r_ff};
      end else begin : g_full
         assign quotient  = zero_ff ? '0 : q_ff;
         assign remainder = zero_ff ? '0 : r_ff;
      end
   endgenerate
   assign div_by_zero = zero_ff;

endmodule

// ----- hw/rtl/idv_ctrl.sv -----
`timescale 1ns / 1ps

module idv_ctrl #(
   parameter int DATA_WIDTH = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output logic                    rsp_valid,
   output idv_pkg::idv_cmd_type    cmd,
   input  idv_pkg::idv_status_type status
);
   import idv_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PREP = 3'd1;
   localparam logic [2:0] ST_RUN  = 3'd2;
   localparam logic [2:0] ST_FIX  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   localparam int              CW       = $clog2(DATA_WIDTH);
   localparam logic [CW-1:0]   CNT_LAST = CW'(DATA_WIDTH - 1);

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            cnt_in   = CNT_LAST;
            // zero divisor: skip the iterations
            state_in = status.div_zero ? ST_DONE : ST_RUN;
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = ST_FIX;
         end
         ST_FIX: begin
            cmd.fix  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

endmodule

// ----- hw/rtl/int64_divider.sv -----
`timescale 1ns / 1ps

// Restoring shift-subtract divider giving quotient and remainder together,
// unsigned (req_opcode 0) or signed truncating toward zero (req_opcode 1).
// A word is taken when start is high and busy is low; busy then stays high
// until the result has been shown. After acceptance the prep state takes
// magnitudes, the run state forms one quotient bit per step in the shared
// subtractor, and the fix state restores signs before rsp_valid rises.
// The result is taken at the edge that ends the rsp_valid cycle. A new word can
// be taken in the cycle after rsp_valid. A zero divisor skips the iterations:
// the prep state goes straight to the done state, with rsp_div_by_zero set and
// both results zero. rsp_valid lasts exactly one cycle and cannot be stalled:
// the receiver must capture the word then.
// Bits above DATA_WIDTH in the operands are ignored and read as zero in the
// results.
module int64_divider #(
   parameter int DATA_WIDTH = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_opcode,
   input  logic [idv_pkg::FIELD_WIDTH-1:0] req_dividend,
   input  logic [idv_pkg::FIELD_WIDTH-1:0] req_divisor,
   output logic                            rsp_valid,
   output logic [idv_pkg::FIELD_WIDTH-1:0] rsp_quotient,
   output logic [idv_pkg::FIELD_WIDTH-1:0] rsp_remainder,
   output logic                            rsp_div_by_zero
);
   import idv_pkg::*;

   idv_cmd_type    cmd;
   idv_status_type status;

   idv_ctrl #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   idv_datapath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .cmd         (cmd),
      .status      (status),
      .opcode      (req_opcode),
      .dividend    (req_dividend),
      .divisor     (req_divisor),
      .quotient    (rsp_quotient),
      .remainder   (rsp_remainder),
      .div_by_zero (rsp_div_by_zero)
   );

endmodule

// ----- hw/rtl/idv_checker.sv -----
`timescale 1ns / 1ps

module idv_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_valid,
   input logic [idv_pkg::FIELD_WIDTH-1:0] rsp_quotient,
   input logic [idv_pkg::FIELD_WIDTH-1:0] rsp_remainder,
   input logic                            rsp_div_by_zero
);

   // a result only shows while a word is in flight
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("rsp_valid without busy");

   // an accepted word makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   // the block frees up right after the result
   a_valid_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy && !rsp_valid)
      else $error("busy or rsp_valid held after result");

   // zero divisor returns zero results
   a_zero_results: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_by_zero |-> rsp_quotient == '0 && rsp_remainder == '0)
      else $error("nonzero results on zero divisor");

endmodule

bind int64_divider idv_checker u_idv_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_quotient    (rsp_quotient),
   .rsp_remainder   (rsp_remainder),
   .rsp_div_by_zero (rsp_div_by_zero)
);

// ----- bench/div_checker.sv -----
`timescale 1ns / 1ps

module div_checker #(
   parameter int DATA_WIDTH = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  logic                            req_opcode,
   input  logic [idv_pkg::FIELD_WIDTH-1:0] req_dividend,
   input  logic [idv_pkg::FIELD_WIDTH-1:0] req_divisor,
   input  logic                            rsp_valid,
   input  logic [idv_pkg::FIELD_WIDTH-1:0] rsp_quotient,
   input  logic [idv_pkg::FIELD_WIDTH-1:0] rsp_remainder,
   input  logic                            rsp_div_by_zero,
   output int                              n_fail,
   output int                              n_pending
);

   localparam int FW = idv_pkg::FIELD_WIDTH;

   typedef logic [FW-1:0] word_type;

   localparam word_type WIDTH_MASK = {FW{1'b1}} >> (FW - DATA_WIDTH);
   localparam word_type SIGN_BIT   = word_type'(1) << (DATA_WIDTH - 1);

   typedef struct packed {
      word_type quotient;
      word_type remainder;
      logic     div_by_zero;
   } div_answer_type;

   div_answer_type pending_answers[$];
   int             fail_count = 0;
   int             answer_count = 0;

   assign n_fail    = fail_count;
   assign n_pending = answer_count;

   // Divide on magnitudes, then give the quotient the xor of the signs and
   // the remainder the sign of the dividend.
   function automatic div_answer_type divide_word(input logic     is_signed,
                                                  input word_type dividend,
                                                  input word_type divisor);
      div_answer_type answer;
      word_type       num;
      word_type       den;
      logic           num_neg;
      logic           den_neg;
      num     = dividend & WIDTH_MASK;
      den     = divisor & WIDTH_MASK;
      num_neg = 1'b0;
      den_neg = 1'b0;
      if (den == '0) begin
         answer.quotient    = '0;
         answer.remainder   = '0;
         answer.div_by_zero = 1'b1;
         return answer;
      end
      if (is_signed) begin
         if ((num & SIGN_BIT) != '0) begin
            num_neg = 1'b1;
            num     = (-num) & WIDTH_MASK;
         end
         if ((den & SIGN_BIT) != '0) begin
            den_neg = 1'b1;
            den     = (-den) & WIDTH_MASK;
         end
      end
      answer.quotient    = num / den;
      answer.remainder   = num % den;
      answer.div_by_zero = 1'b0;
      if (num_neg != den_neg)
         answer.quotient = (-answer.quotient) & WIDTH_MASK;
      if (num_neg)
         answer.remainder = (-answer.remainder) & WIDTH_MASK;
      return answer;
   endfunction

   always @(posedge clock) begin
      div_answer_type want;
      int             errs;
      errs = 0;
      if (!reset) begin
         // Check before queueing, so a word taken at this edge is never matched
         if (rsp_valid) begin
            if (pending_answers.size() == 0) begin
               $display("%0t: result with nothing outstanding: q=%h r=%h z=%b",
                        $time, rsp_quotient, rsp_remainder, rsp_div_by_zero);
               errs++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_quotient !== want.quotient) begin
                  $display("%0t: quotient expected %h actual %h",
                           $time, want.quotient, rsp_quotient);
                  errs++;
               end
               if (rsp_remainder !== want.remainder) begin
                  $display("%0t: remainder expected %h actual %h",
                           $time, want.remainder, rsp_remainder);
                  errs++;
               end
               if (rsp_div_by_zero !== want.div_by_zero) begin
                  $display("%0t: div_by_zero expected %b actual %b",
                           $time, want.div_by_zero, rsp_div_by_zero);
                  errs++;
               end
            end
         end
         if (start && !busy)
            pending_answers.push_back(divide_word(req_opcode, req_dividend, req_divisor));
      end
      fail_count   <= fail_count + errs;
      answer_count <= pending_answers.size();
   end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   localparam int FW          = idv_pkg::FIELD_WIDTH;
   localparam int N_RANDOM    = 2000;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_WAIT  = 80;

   typedef logic [FW-1:0] word_type;

   localparam word_type MOST_NEG = {1'b1, {(FW-1){1'b0}}};
   localparam word_type MOST_POS = {1'b0, {(FW-1){1'b1}}};
   localparam word_type ALL_ONES = {FW{1'b1}};

   localparam logic OP_UNSIGNED = 1'b0;
   localparam logic OP_SIGNED   = 1'b1;

   logic     clock;
   logic     reset;
   logic     start;
   logic     busy;
   logic     req_opcode;
   word_type req_dividend;
   word_type req_divisor;
   logic     rsp_valid;
   word_type rsp_quotient;
   word_type rsp_remainder;
   logic     rsp_div_by_zero;
   int       n_fail;
   int       n_pending;
   int       stall_cycles = 0;

   int64_divider i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_dividend   (req_dividend),
      .req_divisor    (req_divisor),
      .rsp_valid      (rsp_valid),
      .rsp_quotient   (rsp_quotient),
      .rsp_remainder  (rsp_remainder),
      .rsp_div_by_zero(rsp_div_by_zero)
   );

   div_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_dividend   (req_dividend),
      .req_divisor    (req_divisor),
      .rsp_valid      (rsp_valid),
      .rsp_quotient   (rsp_quotient),
      .rsp_remainder  (rsp_remainder),
      .rsp_div_by_zero(rsp_div_by_zero),
      .n_fail         (n_fail),
      .n_pending      (n_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // End the run if neither a word nor a result moves for too long
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic word_type pick_operand();
      word_type v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0, 1, 2: ;
         3, 4:    v = v >> $urandom_range(1, FW - 1);
         5:       v = word_type'($urandom_range(0, 15));
         6:       v = -word_type'($urandom_range(1, 16));
         7:       v = MOST_NEG ^ word_type'($urandom_range(0, 3));
         8:       v = MOST_POS - word_type'($urandom_range(0, 3));
         default: v = ~(v >> $urandom_range(1, FW - 1));
      endcase
      return v;
   endfunction

   function automatic int pick_gap();
      int n;
      n = 0;
      // Now and then idle long enough to land anywhere in a division
      if ($urandom_range(0, 19) == 0)
         return $urandom_range(1, 80);
      while ($urandom_range(0, 99) < 31)
         n++;
      return n;
   endfunction

   // Present a word and hold it until the divider takes it
   task automatic send_word(input logic op, input word_type a, input word_type b);
      start        <= 1'b1;
      req_opcode   <= op;
      req_dividend <= a;
      req_divisor  <= b;
      do
         @(posedge clock);
      while (!(start && !busy));
   endtask

   task automatic idle_cycles(input int n);
      start <= 1'b0;
      repeat (n) begin
         req_opcode   <= 1'($urandom);
         req_dividend <= {$urandom, $urandom};
         req_divisor  <= {$urandom, $urandom};
         @(posedge clock);
      end
   endtask

   task automatic issue(input logic op, input word_type a, input word_type b,
                        input bit may_idle);
      int gap;
      send_word(op, a, b);
      gap = may_idle ? pick_gap() : 0;
      if (gap > 0)
         idle_cycles(gap);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do
         @(posedge clock);
      while (n_pending != 0);
   endtask

   initial begin
      logic     op;
      word_type a;
      word_type b;
      start        <= 1'b0;
      req_opcode   <= 1'b0;
      req_dividend <= '0;
      req_divisor  <= '0;
      reset        <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      issue(OP_UNSIGNED, '0, word_type'(1), 1'b1);
      issue(OP_UNSIGNED, ALL_ONES, word_type'(1), 1'b1);
      issue(OP_UNSIGNED, ALL_ONES, ALL_ONES, 1'b1);
      issue(OP_UNSIGNED, word_type'(5), '0, 1'b1);
      issue(OP_UNSIGNED, ALL_ONES, '0, 1'b1);
      issue(OP_UNSIGNED, '0, '0, 1'b1);
      issue(OP_UNSIGNED, word_type'(100), word_type'(7), 1'b1);
      issue(OP_UNSIGNED, word_type'(7), word_type'(100), 1'b1);
      issue(OP_UNSIGNED, word_type'(1), ALL_ONES, 1'b1);
      issue(OP_UNSIGNED, ALL_ONES, MOST_NEG, 1'b1);
      issue(OP_UNSIGNED, MOST_NEG, ALL_ONES, 1'b1);
      issue(OP_SIGNED, MOST_NEG, ALL_ONES, 1'b1);
      issue(OP_SIGNED, MOST_NEG, word_type'(1), 1'b1);
      issue(OP_SIGNED, -word_type'(7), word_type'(2), 1'b1);
      issue(OP_SIGNED, word_type'(7), -word_type'(2), 1'b1);
      issue(OP_SIGNED, -word_type'(7), -word_type'(2), 1'b1);
      issue(OP_SIGNED, MOST_NEG, MOST_NEG, 1'b1);
      issue(OP_SIGNED, MOST_POS, MOST_NEG, 1'b1);
      issue(OP_SIGNED, MOST_NEG, MOST_POS, 1'b1);
      issue(OP_SIGNED, ALL_ONES, '0, 1'b1);
      issue(OP_SIGNED, '0, ALL_ONES, 1'b1);
      issue(OP_SIGNED, MOST_NEG, word_type'(2), 1'b1);
      issue(OP_SIGNED, MOST_POS, ALL_ONES, 1'b1);

      for (int i = 0; i < N_RANDOM; i++) begin
         op = 1'($urandom_range(0, 1));
         a  = pick_operand();
         b  = ($urandom_range(0, 99) < 3) ? '0 : pick_operand();
         // Back to back with no idling through one stretch
         issue(op, a, b, !(i >= 600 && i < 900));
         if (i == 1200)
            wait_drained();
      end

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (n_fail == 0 && n_pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/idv_pkg.sv
hw/rtl/idv_datapath.sv
hw/rtl/idv_ctrl.sv
hw/rtl/int64_divider.sv
hw/rtl/idv_checker.sv
bench/div_checker.sv
bench/tb_top.sv
